### rtl/core/rebed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and button event decoder - shared definitions
// Item layouts, operation and event codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package rebed_pkg;

   localparam int TIME_W  = 16;
   localparam int COUNT_W = 15;
   localparam int KIND_W  = 3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FETCH  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ENTER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UP    = 3'd4;

   localparam logic [1:0] BEV_NONE  = 2'd0;
   localparam logic [1:0] BEV_SHORT = 2'd1;
   localparam logic [1:0] BEV_LONG  = 2'd2;

   localparam logic REG_SHORT_PRESS = 1'b0;
   localparam logic REG_LONG_PRESS  = 1'b1;

   localparam logic [TIME_W-1:0] SHORT_PRESS_RESET = 16'd10;
   localparam logic [TIME_W-1:0] LONG_PRESS_RESET  = 16'd300;
   localparam logic [2:0]        LEVELS_RESET      = 3'b111;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              button_level;
      logic              direction_level;
      logic              clock_level;
      logic              operation;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  event_kind;
      logic [COUNT_W-1:0] event_count;
      logic               event_pending;
   } rsp_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] short_press_ms;
      logic [TIME_W-1:0] long_press_ms;
   } cfg_type;

endpackage

### rtl/core/rebed_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and button event decoder - register file
// Press thresholds behind a simple APB-style slave.
// ----------------------------------------------------------------------------
module rebed_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output rebed_pkg::cfg_type  cfg
);
   import rebed_pkg::*;

   logic [TIME_W-1:0] short_ff, short_in;
   logic [TIME_W-1:0] long_ff, long_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      short_in = short_ff;
      long_in  = long_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SHORT_PRESS: short_in = csr_pwdata[TIME_W-1:0];
            REG_LONG_PRESS:  long_in  = csr_pwdata[TIME_W-1:0];
            default:         short_in = short_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= SHORT_PRESS_RESET;
         long_ff  <= LONG_PRESS_RESET;
      end else begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SHORT_PRESS: csr_prdata = {16'd0, short_ff};
         REG_LONG_PRESS:  csr_prdata = {16'd0, long_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.short_press_ms = short_ff;
   assign cfg.long_press_ms  = long_ff;

endmodule

### rtl/core/rebed_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and button event decoder - event logic
// Decoder state and the single-pass update for one sample or fetch.
// ----------------------------------------------------------------------------
module rebed_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  rebed_pkg::req_item_type  item,
   input  rebed_pkg::cfg_type       cfg,
   output rebed_pkg::rsp_item_type  result
);
   import rebed_pkg::*;

   logic [2:0]               levels_ff, levels_in;
   logic [TIME_W-1:0]        start_ff, start_in;
   logic [1:0]               bev_ff, bev_in;
   logic signed [TIME_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0]        press_len;
   logic [1:0]               enc;
   logic [TIME_W:0]          mag;
   logic [KIND_W-1:0]        kind;
   logic [COUNT_W-1:0]       count;

   assign press_len = item.time_ms - start_ff;
   assign enc       = {item.direction_level, item.clock_level};
   assign mag       = -{step_ff[TIME_W-1], step_ff};

   always_comb begin
      levels_in = levels_ff;
      start_in  = start_ff;
      bev_in    = bev_ff;
      step_in   = step_ff;
      kind      = KIND_NONE;
      count     = '0;
      unique case (item.operation)
         OP_SAMPLE: begin
            priority if (levels_ff[2] && !item.button_level) begin
               start_in = item.time_ms;
            end else if (!levels_ff[2] && item.button_level) begin
               priority if (press_len >= cfg.long_press_ms) begin
                  bev_in = BEV_LONG;
               end else if (press_len >= cfg.short_press_ms) begin
                  bev_in = BEV_SHORT;
               end else begin
                  bev_in = bev_ff;
               end
            end else begin
               start_in = start_ff;
            end
            if ((levels_ff[1:0] ^ enc) == 2'b01) begin
               if (enc == 2'b00 || enc == 2'b11) begin
                  if (step_ff != 16'sh8000) step_in = step_ff - 16'sd1;
               end else begin
                  if (step_ff != 16'sh7fff) step_in = step_ff + 16'sd1;
               end
            end
            levels_in = {item.button_level, enc};
         end
         OP_FETCH: begin
            priority if (bev_ff == BEV_SHORT) begin
               kind   = KIND_ENTER;
               bev_in = BEV_NONE;
            end else if (bev_ff == BEV_LONG) begin
               kind   = KIND_CLEAR;
               bev_in = BEV_NONE;
            end else if (step_ff >= 16'sd2) begin
               kind    = KIND_DOWN;
               count   = step_ff[TIME_W-1:1];
               step_in = {15'd0, step_ff[0]};
            end else if (step_ff <= -16'sd2) begin
               kind    = KIND_UP;
               count   = mag[TIME_W-1:1];
               step_in = {TIME_W{mag[0]}};
            end else begin
               kind = KIND_NONE;
            end
         end
         default: kind = KIND_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         start_ff  <= '0;
         bev_ff    <= BEV_NONE;
         step_ff   <= '0;
      end else if (load) begin
         levels_ff <= levels_in;
         start_ff  <= start_in;
         bev_ff    <= bev_in;
         step_ff   <= step_in;
      end
   end

   assign result.event_kind    = kind;
   assign result.event_count   = count;
   assign result.event_pending = (bev_in != BEV_NONE) || (step_in >= 16'sd2)
                                 || (step_in <= -16'sd2);

`ifndef SYNTHESIS
   a_fetch_clears_button: assert property (@(posedge clock) disable iff (reset)
      load && item.operation == OP_FETCH && bev_ff != BEV_NONE |=> bev_ff == BEV_NONE)
      else $error("button event survived its fetch");
   a_down_leaves_remainder: assert property (@(posedge clock) disable iff (reset)
      load && item.operation == OP_FETCH && bev_ff == BEV_NONE && step_ff >= 16'sd2
      |=> step_ff == 16'sd0 || step_ff == 16'sd1)
      else $error("step count not reduced after down event");
`endif

endmodule

### rtl/core/rotary_encoder_button_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and button event decoder - top level
// Pin samples become press events and a saturating step count; fetches
// hand out one event at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | content
//  req_    | in        | tvalid / tready      | tuser operation, tdata pins + time
//  rsp_    | out       | tvalid / tready      | tuser event kind, tdata count + pending
//  csr_    | in        | psel/penable/pready  | press thresholds, 4-byte stride
//
//  One request per clock sustained while the result is not stalled.
//  Input register, combinational decode logic, then the result register.
//  Reset clears the decoder state and thresholds to 10 ms and 300 ms.
//  A stalled result holds the result register; the input register still
//  takes one more request while it is free.
// ----------------------------------------------------------------------------
module rotary_encoder_button_event_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // clock_level, direction_level, button_level, time_ms[15:0]
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // event_count[14:0], event_pending
   output logic [2:0]  rsp_tuser,   // event_kind[2:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rebed_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;
   logic         advance;
   logic         req_fire;

   rebed_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.operation       = req_tuser[0];
      in_item_in.clock_level     = req_tdata[0];
      in_item_in.direction_level = req_tdata[1];
      in_item_in.button_level    = req_tdata[2];
      in_item_in.time_ms         = req_tdata[18:3];
   end

   always_comb begin
      priority if (req_fire) in_valid_in = 1'b1;
      else if (advance)      in_valid_in = 1'b0;
      else                   in_valid_in = in_valid_ff;
      priority if (advance)  rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   rebed_core u_core (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) in_item_ff <= in_item_in;
      if (advance)  rsp_item_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.event_pending, rsp_item_ff.event_count};
   assign rsp_tuser  = rsp_item_ff.event_kind;

`ifndef SYNTHESIS
   a_count_only_on_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DOWN && rsp_tuser != KIND_UP
      |-> rsp_tdata[14:0] == 15'd0)
      else $error("count reported without a step event");
   a_request_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("held request lost while result stalled");
`endif

endmodule

### sim/tb_rotary_encoder_button_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and button event decoder - self-checking testbench
// Drives pin samples and fetches through the request stream with random
// gaps and back-pressure. It predicts each result from a behavioural copy
// of the press timing, step counting and fetch priority, and compares every
// field. The run covers a directed table, a short sweep of the step count
// and random traffic under several press thresholds.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_event_decoder;
   import rebed_pkg::*;

   localparam logic signed [15:0] STEP_FLOOR = 16'sh8000;
   localparam logic signed [15:0] STEP_CEIL  = 16'sh7FFF;

   typedef struct packed {
      req_item_type item;
      logic         pinned;
      rsp_item_type want;
   } request_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // clock_level, direction_level, button_level, time_ms[15:0]
   logic [0:0]  req_tuser   = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // event_count[14:0], event_pending
   logic [2:0]  rsp_tuser;          // event_kind[2:0]
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // decoder state as predicted
   logic [2:0]         levels_seen = LEVELS_RESET;
   logic [15:0]        press_at    = '0;
   logic [1:0]         button_ev   = BEV_NONE;
   logic signed [15:0] steps       = '0;
   logic [15:0]        short_ms    = SHORT_PRESS_RESET;
   logic [15:0]        long_ms     = LONG_PRESS_RESET;

   rsp_item_type    awaited_events [$];
   request_row_type directed_rows [$];
   request_row_type active_row = '0;

   // pin levels and time last sent
   logic [1:0]  enc_now  = 2'b11;
   logic        btn_now  = 1'b1;
   logic [15:0] clock_ms = '0;

   int          idle_pct        = 18;
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned kind_tally [0:7];

   rotary_encoder_button_event_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rsp_item_type decode_request(input req_item_type r);
      rsp_item_type res;
      logic [1:0]   enc;
      logic [15:0]  held_ms;
      logic [15:0]  mag;
      res = '0;
      res.event_kind = KIND_NONE;
      if (r.operation == OP_SAMPLE) begin
         enc = {r.direction_level, r.clock_level};
         if (levels_seen[2] && !r.button_level) begin
            press_at = r.time_ms;
            levels_seen[2] = 1'b0;
         end else if (!levels_seen[2] && r.button_level) begin
            held_ms = r.time_ms - press_at;
            if (held_ms >= long_ms) begin
               button_ev = BEV_LONG;
            end else if (held_ms >= short_ms) begin
               button_ev = BEV_SHORT;
            end
            levels_seen[2] = 1'b1;
         end
         if (enc != levels_seen[1:0]) begin
            if ((enc ^ levels_seen[1:0]) == 2'b01) begin
               if (enc == 2'b00 || enc == 2'b11) begin
                  if (steps != STEP_FLOOR) steps = steps - 16'sd1;
               end else if (steps != STEP_CEIL) begin
                  steps = steps + 16'sd1;
               end
            end
            levels_seen[1:0] = enc;
         end
      end else if (button_ev == BEV_SHORT) begin
         res.event_kind = KIND_ENTER;
         button_ev = BEV_NONE;
      end else if (button_ev == BEV_LONG) begin
         res.event_kind = KIND_CLEAR;
         button_ev = BEV_NONE;
      end else if (steps >= 2) begin
         res.event_kind = KIND_DOWN;
         res.event_count = steps[15:1];
         steps = {15'd0, steps[0]};
      end else if (steps <= -2) begin
         mag = -steps;
         res.event_kind = KIND_UP;
         res.event_count = mag[15:1];
         steps = mag[0] ? -16'sd1 : 16'sd0;
      end
      res.event_pending = (button_ev != BEV_NONE) || (steps >= 2) || (steps <= -2);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("MISMATCH at %0t ns, result %0d: %s", $time, results_checked, what);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.event_kind    = rsp_tuser;
            seen.event_count   = rsp_tdata[14:0];
            seen.event_pending = rsp_tdata[15];
            if (awaited_events.size() == 0) begin
               report_mismatch("result arrived with nothing awaited");
            end else begin
               want = awaited_events.pop_front();
               kind_tally[want.event_kind]++;
               if (seen.event_kind !== want.event_kind)
                  report_mismatch($sformatf("event_kind got %0d want %0d",
                                            seen.event_kind, want.event_kind));
               if (seen.event_count !== want.event_count)
                  report_mismatch($sformatf("event_count got %0d want %0d",
                                            seen.event_count, want.event_count));
               if (seen.event_pending !== want.event_pending)
                  report_mismatch($sformatf("event_pending got %0b want %0b",
                                            seen.event_pending, want.event_pending));
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            want = decode_request(active_row.item);
            awaited_events.push_back(active_row.pinned ? active_row.want : want);
            requests_sent++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   function automatic request_row_type sample_row(input logic clk, input logic dir,
                                                  input logic btn, input logic [15:0] t);
      request_row_type row;
      row = '0;
      row.item.operation       = OP_SAMPLE;
      row.item.clock_level     = clk;
      row.item.direction_level = dir;
      row.item.button_level    = btn;
      row.item.time_ms         = t;
      return row;
   endfunction

   function automatic request_row_type fetch_row();
      request_row_type row;
      row = '0;
      row.item.operation       = OP_FETCH;
      row.item.clock_level     = 1'($urandom_range(0, 1));
      row.item.direction_level = 1'($urandom_range(0, 1));
      row.item.button_level    = 1'($urandom_range(0, 1));
      row.item.time_ms         = 16'($urandom);
      return row;
   endfunction

   function automatic request_row_type pinned(input request_row_type row,
                                              input logic [2:0] kind,
                                              input logic [14:0] count, input logic pend);
      request_row_type res;
      res = row;
      res.pinned             = 1'b1;
      res.want.event_kind    = kind;
      res.want.event_count   = count;
      res.want.event_pending = pend;
      return res;
   endfunction

   function automatic logic [15:0] next_ms();
      if ($urandom_range(0, 15) == 0) return 16'($urandom);
      return clock_ms + 16'($urandom_range(0, 20));
   endfunction

   // call at a falling edge; returns at the falling edge after the request is taken
   task automatic issue(input request_row_type row);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      active_row <= row;
      req_tvalid <= 1'b1;
      req_tuser  <= row.item.operation;
      req_tdata  <= {5'd0, row.item.time_ms, row.item.button_level,
                     row.item.direction_level, row.item.clock_level};
      if (row.item.operation == OP_SAMPLE) begin
         enc_now  = {row.item.direction_level, row.item.clock_level};
         btn_now  = row.item.button_level;
         clock_ms = row.item.time_ms;
      end
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // one quadrature step; every second step moves the count
   task automatic turn_step(input logic count_down);
      logic [1:0] enc;
      enc = enc_now;
      if ((enc[0] == enc[1]) == count_down) enc ^= 2'b10;
      else enc ^= 2'b01;
      issue(sample_row(enc[0], enc[1], btn_now, next_ms()));
   endtask

   task automatic press_and_release();
      logic [15:0] start_ms;
      logic [15:0] held;
      start_ms = next_ms();
      issue(sample_row(enc_now[0], enc_now[1], 1'b0, start_ms));
      repeat ($urandom_range(0, 2)) turn_step(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 6))
         0: held = short_ms - 16'd1;
         1: held = short_ms;
         2: held = long_ms - 16'd1;
         3: held = long_ms;
         4: held = 16'($urandom);
         5: held = 16'($urandom_range(0, 600));
         default: held = '0;
      endcase
      issue(sample_row(enc_now[0], enc_now[1], 1'b1, start_ms + held));
   endtask

   task automatic random_traffic(input int unsigned amount);
      int unsigned stop_at;
      int unsigned pick;
      logic        count_down;
      stop_at = requests_sent + amount;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            issue(fetch_row());
         end else if (pick < 55) begin
            count_down = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 8)) turn_step(count_down);
         end else if (pick < 82) begin
            press_and_release();
         end else begin
            issue(sample_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 16'($urandom)));
         end
      end
   endtask

   // drop valid and wait for every awaited result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_SHORT_PRESS) short_ms = value;
      else long_ms = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'd0, value})
         report_mismatch($sformatf("register %0d read %0h want %0h", idx, csr_prdata, value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [31:0] phase_thresholds(input int p);
      case (p)
         0: return {16'd0, 16'd0};
         1: return {16'hFFFF, 16'hFFFF};
         2: return {16'd500, 16'd100};
         3: return {16'($urandom_range(0, 400)), 16'($urandom_range(0, 1000))};
         4: return {16'd1, 16'd2};
         default: return {SHORT_PRESS_RESET, LONG_PRESS_RESET};
      endcase
   endfunction

   initial begin : run
      logic [31:0] thresholds;
      int          phase;
      foreach (kind_tally[k]) kind_tally[k] = 0;

      // reset thresholds: 10 ms short, 300 ms long
      directed_rows.push_back(pinned(fetch_row(), KIND_NONE, 15'd0, 1'b0));
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b1, 16'h0000),
                                     KIND_NONE, 15'd0, 1'b0));
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b0, 16'd100),
                                     KIND_NONE, 15'd0, 1'b0));
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b1, 16'd400),
                                     KIND_NONE, 15'd0, 1'b1));
      directed_rows.push_back(pinned(fetch_row(), KIND_CLEAR, 15'd0, 1'b0));
      // press timed across the wrap of the millisecond stamp
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b0, 16'hFFF8),
                                     KIND_NONE, 15'd0, 1'b0));
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b1, 16'h0002),
                                     KIND_NONE, 15'd0, 1'b1));
      // too short: earlier event kept
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b0, 16'h0010),
                                     KIND_NONE, 15'd0, 1'b1));
      directed_rows.push_back(pinned(sample_row(1'b1, 1'b1, 1'b1, 16'h0019),
                                     KIND_NONE, 15'd0, 1'b1));
      directed_rows.push_back(pinned(fetch_row(), KIND_ENTER, 15'd0, 1'b0));
      // short then long: newer event overwrites
      directed_rows.push_back(sample_row(1'b1, 1'b1, 1'b0, 16'h1000));
      directed_rows.push_back(sample_row(1'b1, 1'b1, 1'b1, 16'h112B));
      directed_rows.push_back(sample_row(1'b1, 1'b1, 1'b0, 16'h2000));
      directed_rows.push_back(sample_row(1'b1, 1'b1, 1'b1, 16'h212C));
      directed_rows.push_back(pinned(fetch_row(), KIND_CLEAR, 15'd0, 1'b0));
      // two counted steps up, then both levels changing at once
      directed_rows.push_back(sample_row(1'b0, 1'b1, 1'b1, 16'h3000));
      directed_rows.push_back(sample_row(1'b0, 1'b0, 1'b1, 16'h3001));
      directed_rows.push_back(sample_row(1'b1, 1'b0, 1'b1, 16'h3002));
      directed_rows.push_back(sample_row(1'b0, 1'b1, 1'b1, 16'h3003));
      directed_rows.push_back(pinned(fetch_row(), KIND_DOWN, 15'd1, 1'b0));
      directed_rows.push_back(sample_row(1'b1, 1'b1, 1'b1, 16'h3004));
      directed_rows.push_back(sample_row(1'b1, 1'b0, 1'b1, 16'h3005));
      directed_rows.push_back(sample_row(1'b0, 1'b0, 1'b1, 16'hFFFF));
      directed_rows.push_back(pinned(fetch_row(), KIND_UP, 15'd1, 1'b0));
      directed_rows.push_back(pinned(fetch_row(), KIND_NONE, 15'd0, 1'b0));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) issue(directed_rows[i]);
      settle();

      // walk the count both ways and fetch it back
      repeat (60) turn_step(1'b1);
      issue(fetch_row());
      repeat (60) turn_step(1'b0);
      issue(fetch_row());
      settle();

      for (phase = 0; phase < 6; phase++) begin
         thresholds = phase_thresholds(phase);
         idle_pct = (phase == 2) ? 0 : 18;
         write_threshold(REG_SHORT_PRESS, thresholds[31:16]);
         write_threshold(REG_LONG_PRESS, thresholds[15:0]);
         random_traffic(180);
         settle();
      end

      $display("Run covered %0d requests and %0d results: directed table, step count",
               requests_sent, results_checked);
      $display("sweep, 6 threshold settings; enter %0d, clear %0d, down %0d, up %0d, none %0d.",
               kind_tally[KIND_ENTER], kind_tally[KIND_CLEAR], kind_tally[KIND_DOWN],
               kind_tally[KIND_UP], kind_tally[KIND_NONE]);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/rebed_pkg.sv
rtl/core/rebed_csr.sv
rtl/core/rebed_core.sv
rtl/core/rotary_encoder_button_event_decoder.sv
sim/tb_rotary_encoder_button_event_decoder.sv
